// File: rtl/gcps_pkg.sv
package gcps_pkg;

  // Item function codes
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd2;

  // Field widths
  localparam int unsigned CELL_SIZE_W  = 7;
  localparam int unsigned GRID_WIDTH_W = 13;
  localparam int unsigned DIST_W       = 6;
  localparam int unsigned LABEL_W      = 16;
  localparam int unsigned CELL_NUM_W   = 12;
  localparam int unsigned CFG_DATA_W   = 13;

  // Register reset values
  localparam logic [CELL_SIZE_W-1:0]  CELL_SIZE_RST    = 7'd10;
  localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RST   = 13'd64;
  localparam logic [DIST_W-1:0]       MIN_DISTANCE_RST = 6'd0;

  // Smallest usable cell side
  localparam logic [CELL_SIZE_W-1:0]  CELL_SIZE_MIN    = 7'd2;

endpackage

// File: rtl/gcps_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
module gcps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/grid_cell_edge_point_select.sv
// Channel  | Handshake          | Word
// ---------+--------------------+-----------------------------------------------
// input    | start / busy       | in_func, in_pixel_x/y, in_edge_label, in_read_cell
// result   | out_valid (strobe) | out_cell_number, out_updated, out_found, out_chosen_*
// config   | cfg_we             | cfg_index, cfg_wdata
//
// For an update word the cell number and fold distance come from a restoring
// divider that retires one quotient bit per cycle, then a multiply, a table read
// and a write back. A read word goes through a table read, then report and clear.
// Busy stays high from accept through the write back. After reset a clearing pass
// writes every table entry with busy high; configuration writes are taken
// throughout. The result strobe lasts one cycle and the receiver cannot stall
// it.
module grid_cell_edge_point_select #(
  parameter int unsigned MAX_CELLS  = 4096,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_func,
  input  logic [COORD_BITS-1:0]              in_pixel_x,
  input  logic [COORD_BITS-1:0]              in_pixel_y,
  input  logic [gcps_pkg::LABEL_W-1:0]       in_edge_label,
  input  logic [gcps_pkg::CELL_NUM_W-1:0]    in_read_cell,
  // result channel
  output logic                               out_valid,
  output logic [gcps_pkg::CELL_NUM_W-1:0]    out_cell_number,
  output logic                               out_updated,
  output logic                               out_found,
  output logic [COORD_BITS-1:0]              out_chosen_x,
  output logic [COORD_BITS-1:0]              out_chosen_y,
  output logic [gcps_pkg::LABEL_W-1:0]       out_chosen_label,
  output logic [gcps_pkg::DIST_W-1:0]        out_chosen_distance,
  // configuration port
  input  logic                               cfg_we,
  input  logic [gcps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned AW   = $clog2(MAX_CELLS);
  localparam int unsigned CW   = COORD_BITS + gcps_pkg::GRID_WIDTH_W + 1;
  localparam int unsigned SW   = gcps_pkg::CELL_SIZE_W;
  localparam int unsigned DCW  = $clog2(COORD_BITS);
  localparam logic [CW-1:0]  MAX_CELLS_W = CW'(MAX_CELLS);
  localparam logic [AW-1:0]  LAST_CELL   = AW'(MAX_CELLS - 1);
  localparam logic [DCW-1:0] DIV_LAST    = DCW'(COORD_BITS - 1);

  typedef struct packed {
    logic                          valid;
    logic [gcps_pkg::DIST_W-1:0]   distance;
    logic [COORD_BITS-1:0]         x;
    logic [COORD_BITS-1:0]         y;
    logic [gcps_pkg::LABEL_W-1:0]  label;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_RD,
    ST_ACT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [SW-1:0]                       cell_size_r;
  logic [gcps_pkg::GRID_WIDTH_W-1:0]   grid_width_r;
  logic [gcps_pkg::DIST_W-1:0]         min_dist_r;

  // item registers
  logic                                func_r;
  logic [COORD_BITS-1:0]               px_r;
  logic [COORD_BITS-1:0]               py_r;
  logic [gcps_pkg::LABEL_W-1:0]        label_r;
  logic [SW-1:0]                       s_r;
  logic [COORD_BITS-1:0]               dq_x_r;
  logic [COORD_BITS-1:0]               dq_y_r;
  logic [SW-1:0]                       rem_x_r;
  logic [SW-1:0]                       rem_y_r;
  logic [DCW-1:0]                      div_cnt_r;
  logic [CW-1:0]                       cell_r;
  logic                                in_range_r;
  logic [gcps_pkg::DIST_W-1:0]         dist_r;
  logic [AW-1:0]                       clr_cnt_r;

  // result registers
  logic                                out_valid_r;
  logic [gcps_pkg::CELL_NUM_W-1:0]     out_cell_r;
  logic                                out_updated_r;
  logic                                out_found_r;
  entry_t                              out_ent_r;

  // divider step
  logic [SW:0]                         trial_x;
  logic [SW:0]                         trial_y;
  logic                                ge_x;
  logic                                ge_y;
  logic [SW-1:0]                       rem_x_nxt;
  logic [SW-1:0]                       rem_y_nxt;
  logic [COORD_BITS-1:0]               dq_x_nxt;
  logic [COORD_BITS-1:0]               dq_y_nxt;

  // fold, cell number
  logic [SW-1:0]                       other_x;
  logic [SW-1:0]                       other_y;
  logic [SW-1:0]                       fold_x;
  logic [SW-1:0]                       fold_y;
  logic [gcps_pkg::DIST_W-1:0]         dist_nxt;
  logic [COORD_BITS+gcps_pkg::GRID_WIDTH_W-1:0] prod;
  logic [CW-1:0]                       cell_nxt;

  // table access
  logic                                ram_we;
  logic [AW-1:0]                       ram_waddr;
  logic [EW-1:0]                       ram_wdata;
  logic                                ram_re;
  logic [EW-1:0]                       ram_rdata;
  entry_t                              cur_ent;
  entry_t                              new_ent;
  logic                                upd;

  assign busy = (state_r != ST_IDLE);

  // one restoring division step on x and y
  always_comb begin
    trial_x   = {rem_x_r, dq_x_r[COORD_BITS-1]};
    trial_y   = {rem_y_r, dq_y_r[COORD_BITS-1]};
    ge_x      = (trial_x >= {1'b0, s_r});
    ge_y      = (trial_y >= {1'b0, s_r});
    rem_x_nxt = ge_x ? SW'(trial_x - {1'b0, s_r}) : trial_x[SW-1:0];
    rem_y_nxt = ge_y ? SW'(trial_y - {1'b0, s_r}) : trial_y[SW-1:0];
    dq_x_nxt  = {dq_x_r[COORD_BITS-2:0], ge_x};
    dq_y_nxt  = {dq_y_r[COORD_BITS-2:0], ge_y};
  end

  // fold remainders to the nearer grid line, form the cell number
  always_comb begin
    other_x  = s_r - rem_x_r;
    other_y  = s_r - rem_y_r;
    fold_x   = (rem_x_r < other_x) ? rem_x_r : other_x;
    fold_y   = (rem_y_r < other_y) ? rem_y_r : other_y;
    dist_nxt = (fold_x < fold_y) ? gcps_pkg::DIST_W'(fold_x) : gcps_pkg::DIST_W'(fold_y);
    prod     = dq_y_r * grid_width_r;
    cell_nxt = CW'(prod) + CW'(dq_x_r);
  end

  // compare with the stored point
  always_comb begin
    cur_ent          = entry_t'(ram_rdata);
    new_ent.valid    = 1'b1;
    new_ent.distance = dist_r;
    new_ent.x        = px_r;
    new_ent.y        = py_r;
    new_ent.label    = label_r;
    upd = (func_r == gcps_pkg::FUNC_UPDATE) && in_range_r &&
          (label_r != '0) && (dist_r > min_dist_r) &&
          (!cur_ent.valid || (dist_r > cur_ent.distance));
  end

  // table port control
  always_comb begin
    ram_re    = (state_r == ST_RD);
    ram_we    = 1'b0;
    ram_waddr = cell_r[AW-1:0];
    ram_wdata = '0;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
    end else if (state_r == ST_ACT && in_range_r) begin
      if (func_r == gcps_pkg::FUNC_READ) begin
        ram_we = 1'b1;
      end else if (upd) begin
        ram_we    = 1'b1;
        ram_wdata = EW'(new_ent);
      end
    end
  end

  gcps_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_CELLS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cell_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r  <= gcps_pkg::CELL_SIZE_RST;
      grid_width_r <= gcps_pkg::GRID_WIDTH_RST;
      min_dist_r   <= gcps_pkg::MIN_DISTANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gcps_pkg::CFG_CELL_SIZE:    cell_size_r  <= cfg_wdata[SW-1:0];
        gcps_pkg::CFG_GRID_WIDTH:   grid_width_r <= cfg_wdata[gcps_pkg::GRID_WIDTH_W-1:0];
        gcps_pkg::CFG_MIN_DISTANCE: min_dist_r   <= cfg_wdata[gcps_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_ACT);
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_CELL) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            func_r    <= in_func;
            px_r      <= in_pixel_x;
            py_r      <= in_pixel_y;
            label_r   <= in_edge_label;
            dq_x_r    <= in_pixel_x;
            dq_y_r    <= in_pixel_y;
            rem_x_r   <= '0;
            rem_y_r   <= '0;
            div_cnt_r <= '0;
            s_r       <= (cell_size_r < gcps_pkg::CELL_SIZE_MIN) ?
                         gcps_pkg::CELL_SIZE_MIN : cell_size_r;
            cell_r    <= CW'(in_read_cell);
            state_r   <= (in_func == gcps_pkg::FUNC_READ) ? ST_RD : ST_DIV;
          end
        end
        ST_DIV: begin
          rem_x_r   <= rem_x_nxt;
          rem_y_r   <= rem_y_nxt;
          dq_x_r    <= dq_x_nxt;
          dq_y_r    <= dq_y_nxt;
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DIV_LAST) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          cell_r  <= cell_nxt;
          dist_r  <= dist_nxt;
          state_r <= ST_RD;
        end
        ST_RD: begin
          in_range_r <= (cell_r < MAX_CELLS_W);
          state_r    <= ST_ACT;
        end
        ST_ACT: begin
          out_cell_r    <= cell_r[gcps_pkg::CELL_NUM_W-1:0];
          out_updated_r <= upd;
          if (upd) begin
            out_found_r <= 1'b1;
            out_ent_r   <= new_ent;
          end else if (in_range_r && cur_ent.valid) begin
            out_found_r <= 1'b1;
            out_ent_r   <= cur_ent;
          end else begin
            out_found_r <= 1'b0;
            out_ent_r   <= '0;
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cell_number     = out_cell_r;
  assign out_updated         = out_updated_r;
  assign out_found           = out_found_r;
  assign out_chosen_x        = out_ent_r.x;
  assign out_chosen_y        = out_ent_r.y;
  assign out_chosen_label    = out_ent_r.label;
  assign out_chosen_distance = out_ent_r.distance;

`ifndef SYNTHESIS
  // a result only follows the compare cycle
  a_out_after_act: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_ACT))
    else $error("result strobe without a table compare");

  // an accepted word keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not start work");

  // the table is only written while clearing or at write back
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_ACT))
    else $error("table written outside clear or write back");

  // a new chosen point beats the threshold
  a_upd_threshold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_updated |-> out_found && (out_chosen_distance > min_dist_r))
    else $error("update reported below the distance threshold");
`endif

endmodule

// File: test/tb_grid_cell_edge_point_select.sv
`timescale 1ns / 1ps

localparam int PT_COORD_W  = 12;
localparam int TABLE_DEPTH = 4096;
localparam int COORD_MAX   = 4095;
localparam int LBL_W       = gcps_pkg::LABEL_W;
localparam int CELL_W      = gcps_pkg::CELL_NUM_W;
localparam int CFG_DW      = gcps_pkg::CFG_DATA_W;

// One result word of the block
typedef struct packed {
  logic [gcps_pkg::CELL_NUM_W-1:0] cell_number;
  logic                            updated;
  logic                            found;
  logic [PT_COORD_W-1:0]           x;
  logic [PT_COORD_W-1:0]           y;
  logic [gcps_pkg::LABEL_W-1:0]    label;
  logic [gcps_pkg::DIST_W-1:0]     distance;
} cell_report_t;

// Per-cell best edge point table and the queue of reports it predicts
class edge_point_board;
  int cell_side;
  int row_cells;
  int dist_floor;
  bit                            has_point [TABLE_DEPTH];
  bit [gcps_pkg::DIST_W-1:0]     best_dist [TABLE_DEPTH];
  bit [PT_COORD_W-1:0]           best_x    [TABLE_DEPTH];
  bit [PT_COORD_W-1:0]           best_y    [TABLE_DEPTH];
  bit [gcps_pkg::LABEL_W-1:0]    best_label[TABLE_DEPTH];
  cell_report_t                  expected_reports[$];
  int                            mismatches;
  int                            reports_seen;

  function new();
    cell_side    = int'(gcps_pkg::CELL_SIZE_RST);
    row_cells    = int'(gcps_pkg::GRID_WIDTH_RST);
    dist_floor   = int'(gcps_pkg::MIN_DISTANCE_RST);
    mismatches   = 0;
    reports_seen = 0;
  endfunction

  function void set_register(logic [gcps_pkg::CFG_IDX_W-1:0] idx,
                             logic [gcps_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      gcps_pkg::CFG_CELL_SIZE:    cell_side  = int'(data[gcps_pkg::CELL_SIZE_W-1:0]);
      gcps_pkg::CFG_GRID_WIDTH:   row_cells  = int'(data[gcps_pkg::GRID_WIDTH_W-1:0]);
      gcps_pkg::CFG_MIN_DISTANCE: dist_floor = int'(data[gcps_pkg::DIST_W-1:0]);
      default: ;
    endcase
  endfunction

  // distance of a coordinate to the nearer grid line
  function int fold_to_line(int v, int s);
    int r;
    r = v % s;
    return (r < s - r) ? r : s - r;
  endfunction

  function cell_report_t cell_content(int cell_idx, bit upd);
    cell_report_t r;
    r = '0;
    r.cell_number = cell_idx[gcps_pkg::CELL_NUM_W-1:0];
    r.updated     = upd;
    if (cell_idx < TABLE_DEPTH && has_point[cell_idx]) begin
      r.found    = 1'b1;
      r.x        = best_x[cell_idx];
      r.y        = best_y[cell_idx];
      r.label    = best_label[cell_idx];
      r.distance = best_dist[cell_idx];
    end
    return r;
  endfunction

  // append one predicted report
  function void queue_report(cell_report_t r);
    expected_reports = {expected_reports, r};
  endfunction

  // Predict the report of one accepted word and update the table
  function void note_word(logic func, logic [PT_COORD_W-1:0] px, logic [PT_COORD_W-1:0] py,
                          logic [gcps_pkg::LABEL_W-1:0] lbl,
                          logic [gcps_pkg::CELL_NUM_W-1:0] rcell);
    int s, x, y, d, cell_id;
    bit upd;
    upd = 1'b0;
    if (func == gcps_pkg::FUNC_READ) begin
      cell_id = int'(rcell);
      queue_report(cell_content(cell_id, 1'b0));
      has_point[cell_id]  = 1'b0;
      best_dist[cell_id]  = '0;
      best_x[cell_id]     = '0;
      best_y[cell_id]     = '0;
      best_label[cell_id] = '0;
    end else begin
      s = (cell_side < int'(gcps_pkg::CELL_SIZE_MIN)) ?
          int'(gcps_pkg::CELL_SIZE_MIN) : cell_side;
      x = int'(px);
      y = int'(py);
      d = fold_to_line(x, s);
      if (fold_to_line(y, s) < d) d = fold_to_line(y, s);
      cell_id = (y / s) * row_cells + x / s;
      if (lbl != 0 && cell_id < TABLE_DEPTH && d > dist_floor &&
          (!has_point[cell_id] || d > int'(best_dist[cell_id]))) begin
        has_point[cell_id]  = 1'b1;
        best_dist[cell_id]  = d[gcps_pkg::DIST_W-1:0];
        best_x[cell_id]     = px;
        best_y[cell_id]     = py;
        best_label[cell_id] = lbl;
        upd = 1'b1;
      end
      queue_report(cell_content(cell_id, upd));
    end
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task compare_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("word %0d %s got 0x%0h want 0x%0h",
                                reports_seen, name, got, want));
  endtask

  task check_word(cell_report_t got);
    cell_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("unexpected word, cell 0x%0h", got.cell_number));
    end else begin
      want = expected_reports.pop_front();
      compare_field("cell_number", int'(got.cell_number), int'(want.cell_number));
      compare_field("updated", int'(got.updated), int'(want.updated));
      compare_field("found", int'(got.found), int'(want.found));
      compare_field("chosen_x", int'(got.x), int'(want.x));
      compare_field("chosen_y", int'(got.y), int'(want.y));
      compare_field("chosen_label", int'(got.label), int'(want.label));
      compare_field("chosen_distance", int'(got.distance), int'(want.distance));
    end
    reports_seen++;
  endtask
endclass

module tb_grid_cell_edge_point_select;

  localparam int NUM_PHASES   = 7;
  localparam int POOL_CELLS   = 6;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 300000;

  bit clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_func;
  logic [PT_COORD_W-1:0] in_pixel_x;
  logic [PT_COORD_W-1:0] in_pixel_y;
  logic [gcps_pkg::LABEL_W-1:0] in_edge_label;
  logic [gcps_pkg::CELL_NUM_W-1:0] in_read_cell;
  logic out_valid;
  logic [gcps_pkg::CELL_NUM_W-1:0] out_cell_number;
  logic out_updated;
  logic out_found;
  logic [PT_COORD_W-1:0] out_chosen_x;
  logic [PT_COORD_W-1:0] out_chosen_y;
  logic [gcps_pkg::LABEL_W-1:0] out_chosen_label;
  logic [gcps_pkg::DIST_W-1:0] out_chosen_distance;
  logic cfg_we;
  logic [gcps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gcps_pkg::CFG_DATA_W-1:0] cfg_wdata;

  edge_point_board board = new();

  // per-phase settings: cell side, cells per row, distance floor, word count
  int phase_size  [NUM_PHASES] = '{10, 0, 127, 1, 64, 3, 2};
  int phase_width [NUM_PHASES] = '{64, 1, 4096, 4095, 37, 2048, 100};
  int phase_floor [NUM_PHASES] = '{0, 0, 32, 63, 5, 1, 0};
  int phase_words [NUM_PHASES] = '{220, 200, 200, 60, 200, 200, 170};

  // cells the random words keep hitting in the current phase
  int pool_cx [POOL_CELLS];
  int pool_cy [POOL_CELLS];
  int side_now;
  int width_now;
  int cycle_count;

  grid_cell_edge_point_select DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .in_edge_label       (in_edge_label),
    .in_read_cell        (in_read_cell),
    .out_valid           (out_valid),
    .out_cell_number     (out_cell_number),
    .out_updated         (out_updated),
    .out_found           (out_found),
    .out_chosen_x        (out_chosen_x),
    .out_chosen_y        (out_chosen_y),
    .out_chosen_label    (out_chosen_label),
    .out_chosen_distance (out_chosen_distance),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result capture
  always @(posedge clk) begin : result_monitor
    cell_report_t got;
    if (rst_n && out_valid) begin
      got.cell_number = out_cell_number;
      got.updated     = out_updated;
      got.found       = out_found;
      got.x           = out_chosen_x;
      got.y           = out_chosen_y;
      got.label       = out_chosen_label;
      got.distance    = out_chosen_distance;
      board.check_word(got);
    end
  end

  task automatic write_reg(logic [gcps_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DW'(val);
    board.set_register(idx, CFG_DW'(val));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Present one word after a gap and hold it until accepted
  task automatic send_word(int gap, logic func, int px, int py, int lbl, int rcell);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func       = func;
    in_pixel_x    = PT_COORD_W'(px);
    in_pixel_y    = PT_COORD_W'(py);
    in_edge_label = LBL_W'(lbl);
    in_read_cell  = CELL_W'(rcell);
    start         = 1'b1;
    do @(posedge clk); while (busy);
    board.note_word(in_func, in_pixel_x, in_pixel_y, in_edge_label, in_read_cell);
  endtask

  // Mostly updates and reads of the pool cells, the rest fully random
  task automatic random_word(bit no_gap);
    int gap, r, k, px, py, lbl, rc;
    logic func;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    r   = $urandom_range(0, 99);
    k   = $urandom_range(0, POOL_CELLS - 1);
    px  = $urandom_range(0, COORD_MAX);
    py  = $urandom_range(0, COORD_MAX);
    rc  = $urandom_range(0, COORD_MAX);
    lbl = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 65535);
    func = gcps_pkg::FUNC_UPDATE;
    if (r < 60) begin
      px = pool_cx[k] * side_now + $urandom_range(0, side_now - 1);
      py = pool_cy[k] * side_now + $urandom_range(0, side_now - 1);
      if (px > COORD_MAX) px = COORD_MAX;
      if (py > COORD_MAX) py = COORD_MAX;
    end else if (r < 80) begin
      func = gcps_pkg::FUNC_READ;
      rc   = pool_cy[k] * width_now + pool_cx[k];
    end else if (r >= 90) begin
      func = gcps_pkg::FUNC_READ;
    end
    send_word(gap, func, px, py, lbl, rc);
  endtask

  // Let every outstanding word report, then allow the block to settle
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int p, n, k, max_cx, max_cy;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = gcps_pkg::FUNC_UPDATE;
    in_pixel_x    = '0;
    in_pixel_y    = '0;
    in_edge_label = '0;
    in_read_cell  = '0;
    cfg_we        = 1'b0;
    cfg_index     = gcps_pkg::CFG_CELL_SIZE;
    cfg_wdata     = '0;
    cycle_count   = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(gcps_pkg::CFG_CELL_SIZE, phase_size[p]);
      write_reg(gcps_pkg::CFG_GRID_WIDTH, phase_width[p]);
      write_reg(gcps_pkg::CFG_MIN_DISTANCE, phase_floor[p]);

      // pick pool cells that land inside the table
      side_now  = (phase_size[p] < int'(gcps_pkg::CELL_SIZE_MIN)) ?
                  int'(gcps_pkg::CELL_SIZE_MIN) : phase_size[p];
      width_now = phase_width[p];
      for (k = 0; k < POOL_CELLS; k++) begin
        max_cx = width_now - 1;
        if (max_cx > COORD_MAX / side_now) max_cx = COORD_MAX / side_now;
        pool_cx[k] = $urandom_range(0, max_cx);
        max_cy = (COORD_MAX - pool_cx[k]) / width_now;
        if (max_cy > COORD_MAX / side_now) max_cy = COORD_MAX / side_now;
        pool_cy[k] = $urandom_range(0, max_cy);
      end

      // directed words per setting
      case (p)
        0: begin
          send_word(0, gcps_pkg::FUNC_READ, 0, 0, 0, 0);          // read of an empty cell
          send_word(0, gcps_pkg::FUNC_UPDATE, 0, 0, 5, 0);        // on a grid line, no gain
          send_word(0, gcps_pkg::FUNC_UPDATE, 5, 5, 'hffff, 0);   // cell center
          send_word(1, gcps_pkg::FUNC_UPDATE, 4, 6, 1, 0);        // closer to line, kept out
          send_word(0, gcps_pkg::FUNC_UPDATE, 5, 5, 0, 0);        // zero label
          send_word(0, gcps_pkg::FUNC_UPDATE, COORD_MAX, COORD_MAX, 'hffff, 'hfff); // off table
          send_word(2, gcps_pkg::FUNC_UPDATE, 635, 635, 'h8001, 0); // last table cell
          send_word(0, gcps_pkg::FUNC_READ, 0, 0, 0, 'hfff);
          send_word(0, gcps_pkg::FUNC_READ, 0, 0, 0, 'hfff);
          send_word(0, gcps_pkg::FUNC_READ, 0, 0, 0, 0);
          send_word(3, gcps_pkg::FUNC_READ, 0, 0, 0, 0);
        end
        1: begin
          // side below minimum, one cell per row
          send_word(0, gcps_pkg::FUNC_UPDATE, 1, COORD_MAX, 'h1234, 0);
          send_word(0, gcps_pkg::FUNC_UPDATE, COORD_MAX, 0, 7, 0);
          send_word(0, gcps_pkg::FUNC_UPDATE, 3, 4094, 9, 0);
          send_word(0, gcps_pkg::FUNC_READ, 0, 0, 0, 2047);
        end
        2: begin
          // widest cells, distances up to 63, floor at 32
          send_word(0, gcps_pkg::FUNC_UPDATE, 63, 63, 'habcd, 0);
          send_word(0, gcps_pkg::FUNC_UPDATE, 64, 190, 'h5555, 0); // cell 4096 lies off the table
          send_word(0, gcps_pkg::FUNC_UPDATE, 33, 33, 1, 0);
          send_word(0, gcps_pkg::FUNC_UPDATE, 32, 32, 1, 0);
          send_word(0, gcps_pkg::FUNC_READ, 0, 0, 0, 0);
        end
        3: send_word(0, gcps_pkg::FUNC_UPDATE, 1, 1, 1, 0);     // floor blocks everything
        default: ;
      endcase

      for (n = 0; n < phase_words[p]; n++)
        random_word(p == 1 || p == 4);
      drain();
    end

    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: grid_cell_edge_point_select.f
rtl/gcps_pkg.sv
rtl/gcps_ram.sv
rtl/grid_cell_edge_point_select.sv
test/tb_grid_cell_edge_point_select.sv
